/* rtl/lsp_pkg.sv */
`default_nettype none
package lsp_pkg;

  localparam int MAX_ATOMS = 1024;
  localparam int AW        = $clog2(MAX_ATOMS);
  localparam int CW        = AW + 1;
  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 32;
  localparam int BOX_W     = 31;
  localparam int CUT_W     = 40;
  localparam int CFG_W     = 40;
  localparam int CFG_IDX_W = 2;
  localparam int E_W       = 48;
  localparam int SQ_W      = 2 * POS_W;
  localparam int Q_W       = SQ_W - FRAC_BITS;
  localparam int INV2_W    = 2 * FRAC_BITS + 1;
  localparam int PROD_W    = 63;
  localparam int STEP_W    = $clog2(PROD_W);
  localparam int QDEPTH    = 2;

  localparam logic [PROD_W-1:0] PROD_CAP = {1'b1, {(PROD_W-1){1'b0}}};
  localparam logic [PROD_W-1:0] DIFF_MAX = PROD_W'((64'd1 << (E_W - 3)) - 64'd1);
  localparam logic [E_W-1:0]    E_MAX    = {1'b0, {(E_W-1){1'b1}}};
  localparam logic [E_W-1:0]    E_MIN    = {1'b1, {(E_W-1){1'b0}}};

  typedef enum logic {OP_WRITE, OP_QUERY} op_t;

  typedef enum logic [CFG_IDX_W-1:0] {CFG_BOX, CFG_CUTOFF, CFG_COUNT} cfg_idx_t;

  typedef struct packed {
    op_t                     op;
    logic [AW-1:0]           idx;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } item_t;

  typedef struct packed {
    logic                  hit;
    logic                  sat;
    logic signed [E_W-1:0] term;
  } pair_res_t;

  typedef enum logic [2:0] {
    P_IDLE, P_WRAP, P_SQ, P_SUM1, P_SUM2, P_CMP, P_DIV, P_MUL
  } pair_state_t;

  typedef enum logic [2:0] {B_IDLE, B_READ, B_WAIT, B_PAIR, B_DONE} back_state_t;

endpackage
`default_nettype wire

/* rtl/lsp_front.sv */
`default_nettype none
module lsp_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         cmd,
  input  wire logic [lsp_pkg::AW-1:0]       atom_index,
  input  wire logic signed [lsp_pkg::POS_W-1:0] pos_x,
  input  wire logic signed [lsp_pkg::POS_W-1:0] pos_y,
  input  wire logic signed [lsp_pkg::POS_W-1:0] pos_z,
  output logic                              q_valid,
  output lsp_pkg::item_t                    q_item,
  input  wire logic                         q_pop
);
  import lsp_pkg::*;

  item_t      entries [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      in_item;
  logic       push;
  logic       pop;

  always_comb begin
    in_item.op  = cmd ? OP_QUERY : OP_WRITE;
    in_item.idx = atom_index;
    in_item.x   = pos_x;
    in_item.y   = pos_y;
    in_item.z   = pos_z;
  end

  assign in_ready = (count != 2'(QDEPTH));
  assign q_valid  = (count != 2'd0);
  assign q_item   = entries[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/lsp_pair.sv */
`default_nettype none
module lsp_pair (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic signed [lsp_pkg::POS_W-1:0] sx,
  input  wire logic signed [lsp_pkg::POS_W-1:0] sy,
  input  wire logic signed [lsp_pkg::POS_W-1:0] sz,
  input  wire logic signed [lsp_pkg::POS_W-1:0] tx,
  input  wire logic signed [lsp_pkg::POS_W-1:0] ty,
  input  wire logic signed [lsp_pkg::POS_W-1:0] tz,
  input  wire logic [lsp_pkg::BOX_W-1:0]        box_length,
  input  wire logic [lsp_pkg::CUT_W-1:0]        cutoff_sq,
  output logic                                  done,
  output lsp_pkg::pair_res_t                    res
);
  import lsp_pkg::*;

  localparam int DW = POS_W + 1;

  pair_state_t state, state_next;

  logic signed [DW-1:0] d [3];
  logic [SQ_W-1:0]      sq [3];
  logic [SQ_W-1:0]      s;
  logic [CUT_W-1:0]     qd;
  logic [CUT_W-1:0]     rem;
  logic [INV2_W-1:0]    quot;
  logic [STEP_W-1:0]    cnt;
  logic [SQ_W-1:0]      acc;
  logic                 ovf;
  logic [PROD_W-1:0]    ma;
  logic [PROD_W-1:0]    mb;
  logic [1:0]           msel;
  logic [PROD_W-1:0]    inv2;
  logic [PROD_W-1:0]    inv6;

  logic [Q_W-1:0]       q;
  logic                 miss;
  logic                 div_last;
  logic                 mul_last;
  logic [CUT_W:0]       remsh;
  logic [CUT_W:0]       remdif;
  logic                 qbit;
  logic [INV2_W-1:0]    quot_next;
  logic [SQ_W-1:0]      acc_next;
  logic                 ovf_next;
  logic [PROD_W-1:0]    prod;
  logic [PROD_W-1:0]    diff;
  logic                 pos_term;

  function automatic logic signed [DW-1:0] wrap_axis(input logic signed [DW-1:0] v,
                                                     input logic [BOX_W-1:0] b);
    logic [DW-1:0]   a;
    logic [DW:0]     a2;
    logic [DW-1:0]   bx;
    logic signed [DW-1:0] r;
    begin
      a  = v[DW-1] ? DW'(-v) : DW'(v);
      a2 = {a, 1'b0};
      bx = DW'(b);
      r  = v;
      if (a2 > (DW+1)'(b)) begin
        r = v[DW-1] ? (v + $signed(bx)) : (v - $signed(bx));
      end
      wrap_axis = r;
    end
  endfunction

  function automatic logic [SQ_W-1:0] add_sat(input logic [SQ_W-1:0] a,
                                              input logic [SQ_W-1:0] b);
    logic [SQ_W:0] t;
    begin
      t = {1'b0, a} + {1'b0, b};
      add_sat = t[SQ_W] ? {SQ_W{1'b1}} : t[SQ_W-1:0];
    end
  endfunction

  function automatic logic [SQ_W-1:0] square(input logic signed [DW-1:0] v);
    logic [DW-1:0] a;
    begin
      a      = v[DW-1] ? DW'(-v) : DW'(v);
      square = a[POS_W-1:0] * a[POS_W-1:0];
    end
  endfunction

  assign q        = s[SQ_W-1:FRAC_BITS];
  assign miss     = (q >= Q_W'(cutoff_sq));
  assign div_last = (cnt == STEP_W'(INV2_W - 1));
  assign mul_last = (cnt == STEP_W'(PROD_W - 1));
  assign remsh    = {rem, (cnt == '0)};
  assign remdif   = remsh - {1'b0, qd};
  assign qbit     = (remsh >= {1'b0, qd});
  assign quot_next = {quot[INV2_W-2:0], qbit};

  always_comb begin
    acc_next = acc;
    ovf_next = ovf;
    if (!ovf) begin
      acc_next = {acc[SQ_W-2:0], 1'b0} + (mb[PROD_W-1] ? SQ_W'(ma) : '0);
      ovf_next = (acc_next > SQ_W'(PROD_CAP));
    end
    prod = ovf_next ? PROD_CAP : PROD_W'(acc_next[SQ_W-1:FRAC_BITS]);
  end

  always_comb begin
    pos_term = (prod >= inv6);
    diff     = pos_term ? (prod - inv6) : (inv6 - prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      P_IDLE: if (start) state_next = P_WRAP;
      P_WRAP: state_next = P_SQ;
      P_SQ:   state_next = P_SUM1;
      P_SUM1: state_next = P_SUM2;
      P_SUM2: state_next = P_CMP;
      P_CMP:  state_next = (miss || q == '0) ? P_IDLE : P_DIV;
      P_DIV:  if (div_last) state_next = P_MUL;
      P_MUL:  if (mul_last && msel == 2'd2) state_next = P_IDLE;
      default: state_next = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == P_CMP && (miss || q == '0)) ||
              (state == P_MUL && mul_last && msel == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      P_IDLE: begin
        d[0] <= DW'(sx) - DW'(tx);
        d[1] <= DW'(sy) - DW'(ty);
        d[2] <= DW'(sz) - DW'(tz);
      end
      P_WRAP: begin
        for (int i = 0; i < 3; i++) begin
          d[i] <= wrap_axis(d[i], box_length);
        end
      end
      P_SQ: begin
        for (int i = 0; i < 3; i++) begin
          sq[i] <= square(d[i]);
        end
      end
      P_SUM1: s <= add_sat(sq[0], sq[1]);
      P_SUM2: s <= add_sat(s, sq[2]);
      P_CMP: begin
        qd   <= q[CUT_W-1:0];
        rem  <= '0;
        quot <= '0;
        cnt  <= '0;
        res.hit  <= !miss;
        res.sat  <= 1'b1;
        res.term <= E_MAX;
      end
      P_DIV: begin
        rem  <= qbit ? remdif[CUT_W-1:0] : remsh[CUT_W-1:0];
        quot <= quot_next;
        cnt  <= div_last ? '0 : cnt + STEP_W'(1);
        if (div_last) begin
          inv2 <= PROD_W'(quot_next);
          ma   <= PROD_W'(quot_next);
          mb   <= PROD_W'(quot_next);
          msel <= 2'd0;
          acc  <= '0;
          ovf  <= 1'b0;
        end
      end
      P_MUL: begin
        if (mul_last) begin
          acc <= '0;
          ovf <= 1'b0;
          cnt <= '0;
          case (msel)
            2'd0: begin
              ma   <= prod;
              mb   <= inv2;
              msel <= 2'd1;
            end
            2'd1: begin
              inv6 <= prod;
              ma   <= prod;
              mb   <= prod;
              msel <= 2'd2;
            end
            default: begin
              res.hit <= 1'b1;
              if (prod >= PROD_CAP || diff > DIFF_MAX) begin
                res.sat  <= 1'b1;
                res.term <= E_MAX;
              end else begin
                res.sat  <= 1'b0;
                res.term <= pos_term ? $signed({1'b0, diff[E_W-4:0], 2'b00})
                                     : -$signed({1'b0, diff[E_W-4:0], 2'b00});
              end
            end
          endcase
        end else begin
          acc <= acc_next;
          ovf <= ovf_next;
          mb  <= {mb[PROD_W-2:0], 1'b0};
          cnt <= cnt + STEP_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/lsp_back.sv */
`default_nettype none
module lsp_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  input  wire lsp_pkg::item_t               q_item,
  output logic                              q_pop,
  input  wire logic [lsp_pkg::BOX_W-1:0]    box_length,
  input  wire logic [lsp_pkg::CUT_W-1:0]    cutoff_sq,
  input  wire logic [lsp_pkg::CW-1:0]       atom_count,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [lsp_pkg::E_W-1:0]    energy,
  output logic                              saturated
);
  import lsp_pkg::*;

  back_state_t state, state_next;

  logic [3*POS_W-1:0]      mem [MAX_ATOMS];
  logic [3*POS_W-1:0]      rd_data;
  logic [CW-1:0]           ptr;
  logic [CW-1:0]           n;
  logic [AW-1:0]           excl;
  logic signed [POS_W-1:0] tx;
  logic signed [POS_W-1:0] ty;
  logic signed [POS_W-1:0] tz;
  logic signed [E_W-1:0]   acc;
  logic                    sat;
  logic                    tsat;

  logic                    rd_en;
  logic                    pair_start;
  logic                    pair_done;
  pair_res_t               pair_res;
  logic                    at_end;
  logic                    at_excl;
  logic                    out_free;
  logic signed [E_W:0]     sum;

  assign at_end   = (ptr == n);
  assign at_excl  = (ptr == {1'b0, excl});
  assign out_free = !out_valid || out_ready;
  assign sum      = {acc[E_W-1], acc} + {pair_res.term[E_W-1], pair_res.term};

  lsp_pair u_pair (
    .clk        (clk),
    .rst        (rst),
    .start      (pair_start),
    .sx         (rd_data[3*POS_W-1:2*POS_W]),
    .sy         (rd_data[2*POS_W-1:POS_W]),
    .sz         (rd_data[POS_W-1:0]),
    .tx         (tx),
    .ty         (ty),
    .tz         (tz),
    .box_length (box_length),
    .cutoff_sq  (cutoff_sq),
    .done       (pair_done),
    .res        (pair_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    pair_start = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.op == OP_QUERY) begin
            state_next = B_READ;
          end
        end
      end
      B_READ: begin
        if (at_end) begin
          state_next = B_DONE;
        end else if (!at_excl) begin
          rd_en      = 1'b1;
          state_next = B_WAIT;
        end
      end
      B_WAIT: begin
        pair_start = 1'b1;
        state_next = B_PAIR;
      end
      B_PAIR: if (pair_done) state_next = B_READ;
      B_DONE: if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && q_valid && q_item.op == OP_WRITE) begin
      mem[q_item.idx] <= {q_item.x, q_item.y, q_item.z};
    end
    if (rd_en) begin
      rd_data <= mem[ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      n    <= '0;
      acc  <= '0;
      sat  <= 1'b0;
      tsat <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (q_valid && q_item.op == OP_QUERY) begin
            ptr  <= '0;
            n    <= (atom_count > CW'(MAX_ATOMS)) ? CW'(MAX_ATOMS) : atom_count;
            excl <= q_item.idx;
            tx   <= q_item.x;
            ty   <= q_item.y;
            tz   <= q_item.z;
            acc  <= '0;
            sat  <= 1'b0;
            tsat <= 1'b0;
          end
        end
        B_READ: begin
          if (!at_end && at_excl) begin
            ptr <= ptr + CW'(1);
          end
        end
        B_PAIR: begin
          if (pair_done) begin
            ptr <= ptr + CW'(1);
            if (pair_res.hit) begin
              if (pair_res.sat) begin
                tsat <= 1'b1;
              end else if (sum[E_W] != sum[E_W-1]) begin
                acc <= sum[E_W] ? E_MIN : E_MAX;
                sat <= 1'b1;
              end else begin
                acc <= sum[E_W-1:0];
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == B_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_DONE && out_free) begin
      energy    <= tsat ? E_MAX : acc;
      saturated <= sat || tsat;
    end
  end

`ifndef NO_ASSERTIONS
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (state != B_IDLE) |-> (ptr <= n))
    else $error("scan pointer past count");

  a_no_excl_read: assert property (@(posedge clk) disable iff (rst)
    (state == B_WAIT) |-> !at_excl)
    else $error("excluded entry read");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(energy) && $stable(saturated)))
    else $error("pending result changed");

  a_done_only_in_pair: assert property (@(posedge clk) disable iff (rst)
    pair_done |-> (state == B_PAIR))
    else $error("pair result with no scan waiting");
`endif

endmodule
`default_nettype wire

/* rtl/lj_single_particle_energy_unit.sv */
// Write: one cycle in the back end after the two-entry input queue.
// Query: each pair inside the cutoff goes through the bit-serial divider and multiplier;
// a pair beyond the cutoff or at zero distance stops at the distance compare.
// One query is in work at a time; writes queue ahead while it runs.
// Synchronous reset clears control state and sets config to its defaults; the atom table is not cleared.
`default_nettype none
module lj_single_particle_energy_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             cmd,
  input  wire logic [lsp_pkg::AW-1:0]           atom_index,
  input  wire logic signed [lsp_pkg::POS_W-1:0] pos_x,
  input  wire logic signed [lsp_pkg::POS_W-1:0] pos_y,
  input  wire logic signed [lsp_pkg::POS_W-1:0] pos_z,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [lsp_pkg::E_W-1:0]        energy,
  output logic                                  saturated,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lsp_pkg::CFG_W-1:0]        cfg_data
);
  import lsp_pkg::*;

  logic [BOX_W-1:0] box_length;
  logic [CUT_W-1:0] cutoff_sq;
  logic [CW-1:0]    atom_count;
  logic             q_valid;
  item_t            q_item;
  logic             q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_length <= BOX_W'(655360);
      cutoff_sq  <= CUT_W'(409600);
      atom_count <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BOX:    box_length <= cfg_data[BOX_W-1:0];
        CFG_CUTOFF: cutoff_sq  <= cfg_data[CUT_W-1:0];
        CFG_COUNT:  atom_count <= cfg_data[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  lsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .atom_index (atom_index),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  lsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .box_length (box_length),
    .cutoff_sq  (cutoff_sq),
    .atom_count (atom_count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .energy     (energy),
    .saturated  (saturated)
  );

endmodule
`default_nettype wire
